// File: design/wrws_pkg.sv
package wrws_pkg;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    localparam int TOTAL_W = 42;
    localparam int COUNT_W = 11;
    localparam int KEY_W   = 16;
    localparam int WGT_W   = 32;

    // Classified command handed from the front part to the back part
    typedef struct packed {
        t_req              req;
        logic              err;
        logic [KEY_W-1:0]  key;
        logic [WGT_W-1:0]  weight;
        logic [COUNT_W-1:0] start;
        logic [COUNT_W-1:0] stop;
        logic [KEY_W-1:0]  lo;
        logic [KEY_W-1:0]  hi;
    } t_cmd;

endpackage

// File: design/wavelet_range_weight_sum_core.sv
// Weighted range-count engine. Appends load (key, weight) pairs; a query
// returns the sum of weights in positions [range_start, range_end) with
// key_low <= key < key_high (negated when the bounds are reversed). Appends,
// clears and rejected requests go straight to the result; a query visits
// positions range_start to range_end - 1, one store read per position on the
// single read port of the key/weight memories. A two-entry queue lets the
// front accept and check up to two items while the back is busy.
module wavelet_range_weight_sum_core #(
    parameter int KEY_BITS  = 16,
    parameter int MAX_ITEMS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic [15:0]        i_item_key,
    input  logic [31:0]        i_item_weight,
    input  logic [10:0]        i_range_start,
    input  logic [10:0]        i_range_end,
    input  logic [15:0]        i_key_low,
    input  logic [15:0]        i_key_high,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [41:0] o_total,
    output logic [1:0]         o_status,
    output logic [10:0]        o_item_count
);
    import wrws_pkg::*;

    logic q_full, q_push, q_valid, q_pop;
    t_cmd q_in, q_out;

    wrws_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_req_type, .i_item_key, .i_item_weight,
        .i_range_start, .i_range_end, .i_key_low, .i_key_high,
        .i_q_full(q_full), .o_q_push(q_push), .o_q_cmd(q_in)
    );

    wrws_queue u_queue (
        .i_clk, .i_rst_n, .i_push(q_push), .i_cmd(q_in), .o_full(q_full),
        .o_valid(q_valid), .i_pop(q_pop), .o_cmd(q_out)
    );

    wrws_back #(.KEY_BITS(KEY_BITS), .MAX_ITEMS(MAX_ITEMS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_cmd(q_out), .o_q_pop(q_pop),
        .o_valid, .i_stall, .o_total, .o_status, .o_item_count
    );
endmodule

// File: design/wrws_front.sv
module wrws_front #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_req_type,
    input  logic [15:0]            i_item_key,
    input  logic [31:0]            i_item_weight,
    input  logic [10:0]            i_range_start,
    input  logic [10:0]            i_range_end,
    input  logic [15:0]            i_key_low,
    input  logic [15:0]            i_key_high,
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output wrws_pkg::t_cmd         o_q_cmd
);
    import wrws_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          w_fire;
    t_req          w_req;

    assign o_stall  = i_q_full;
    assign w_fire   = i_valid && !i_q_full;
    assign w_req    = t_req'(i_req_type);
    assign o_q_push = w_fire;

    // Classify against the count as it stands after earlier items
    always_comb begin
        o_q_cmd        = '0;
        o_q_cmd.req    = w_req;
        o_q_cmd.key    = i_item_key;
        o_q_cmd.weight = i_item_weight;
        o_q_cmd.start  = i_range_start;
        o_q_cmd.stop   = i_range_end;
        o_q_cmd.lo     = i_key_low;
        o_q_cmd.hi     = i_key_high;
        n_count        = r_count;
        case (w_req)
            REQ_APPEND: begin
                if (r_count >= CW'(MAX_ITEMS)) o_q_cmd.err = 1'b1;
                else n_count = r_count + 1'b1;
            end
            REQ_QUERY: begin
                if (i_range_start > i_range_end ||
                    {{(32-COUNT_W){1'b0}}, i_range_end} > 32'(r_count))
                    o_q_cmd.err = 1'b1;
            end
            REQ_CLEAR: n_count = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else if (w_fire) r_count <= n_count;
    end
endmodule

// File: design/wrws_queue.sv
module wrws_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wrws_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output wrws_pkg::t_cmd o_cmd
);
    import wrws_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];

    // Two-entry queue between front and back
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// File: design/wrws_back.sv
module wrws_back #(
    parameter int KEY_BITS  = 16,
    parameter int MAX_ITEMS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  wrws_pkg::t_cmd                i_q_cmd,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [41:0]            o_total,
    output logic [1:0]                    o_status,
    output logic [10:0]                   o_item_count
);
    import wrws_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int KB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_ACC, S_DONE} t_state;

    logic [KEY_W-1:0] r_kmem [MAX_ITEMS];
    logic [WGT_W-1:0] r_wmem [MAX_ITEMS];

    t_state             r_state;
    t_cmd               r_cmd;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [KEY_W-1:0]   r_rk;
    logic [WGT_W-1:0]   r_rw;
    logic [TOTAL_W-1:0] r_acc;
    logic               r_ovalid;
    logic [TOTAL_W-1:0] r_total;
    logic [1:0]         r_status;
    logic [CW-1:0]      r_ocount;
    logic [KEY_W-1:0]   w_kmask, w_k, w_lo, w_hi;
    logic [TOTAL_W-1:0] w_wext;
    logic               w_take;

    assign w_kmask = KEY_W'((33'd1 << KB) - 33'd1);
    assign w_k     = r_rk & w_kmask;
    assign w_lo    = r_cmd.lo & w_kmask;
    assign w_hi    = r_cmd.hi & w_kmask;
    assign w_wext  = {{(TOTAL_W-WGT_W){r_rw[WGT_W-1]}}, r_rw};
    assign w_take  = (r_state == S_IDLE) && i_q_valid && (!r_ovalid || !i_stall);
    assign o_q_pop = w_take;

    assign o_valid      = r_ovalid;
    assign o_total      = r_total;
    assign o_status     = r_status;
    assign o_item_count = 11'(r_ocount);

    // Store memories: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_take && i_q_cmd.req == REQ_APPEND && !i_q_cmd.err) begin
            r_kmem[r_count[AW-1:0]] <= i_q_cmd.key;
            r_wmem[r_count[AW-1:0]] <= i_q_cmd.weight;
        end
        r_rk <= r_kmem[r_idx[AW-1:0]];
        r_rw <= r_wmem[r_idx[AW-1:0]];
    end

    // Sequencer: read one position a cycle, accumulate in-range weights (subtract them when the bounds are reversed)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && r_state != S_DONE) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (w_take) begin
                    r_cmd <= i_q_cmd;
                    r_acc <= '0;
                    r_idx <= CW'(i_q_cmd.start);
                    case (i_q_cmd.req)
                        REQ_APPEND: if (!i_q_cmd.err) r_count <= r_count + 1'b1;
                        REQ_CLEAR:  r_count <= '0;
                        default: ;
                    endcase
                    if (i_q_cmd.req == REQ_QUERY && !i_q_cmd.err &&
                        i_q_cmd.start != i_q_cmd.stop)
                        r_state <= S_READ;
                    else
                        r_state <= S_DONE;
                end
                S_READ: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (w_k < w_hi && !(w_k < w_lo)) r_acc <= r_acc + w_wext;
                    else if (w_k < w_lo && !(w_k < w_hi)) r_acc <= r_acc - w_wext;
                    if (r_idx == CW'(r_cmd.stop)) r_state <= S_DONE;
                    else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_ACC;
                    end
                end
                S_DONE: if (!r_ovalid || !i_stall) begin
                    r_ovalid <= 1'b1;
                    r_ocount <= r_count;
                    r_total  <= (r_cmd.req == REQ_QUERY && !r_cmd.err) ? r_acc : '0;
                    r_status <= !r_cmd.err ? ST_OK :
                                (r_cmd.req == REQ_APPEND) ? ST_FULL : ST_RANGE;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid && $stable(r_total))
        else $error("result dropped under stall");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == S_IDLE)
        else $error("pop while busy");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("count overrun");
endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import wrws_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int IDLE_LIMIT  = 20000;

    typedef struct packed {
        logic signed [41:0] total;
        t_status            status;
        logic [10:0]        count;
    } t_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_req_type = '0;
    logic [15:0]        i_item_key = '0;
    logic [31:0]        i_item_weight = '0;
    logic [10:0]        i_range_start = '0;
    logic [10:0]        i_range_end = '0;
    logic [15:0]        i_key_low = '0;
    logic [15:0]        i_key_high = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [41:0] o_total;
    logic [1:0]         o_status;
    logic [10:0]        o_item_count;

    // Shadow copy of the store
    logic [15:0] shadow_keys [STORE_DEPTH];
    logic [31:0] shadow_wgts [STORE_DEPTH];
    int          shadow_count;
    t_answer     answer_q[$];
    int          errors = 0;
    int          idle_cycles = 0;

    wavelet_range_weight_sum_core u_dut (.*);

    always #10 i_clk = ~i_clk;

    // Sum of weights in [s, t) with key below x, 42-bit wrap
    function automatic logic [41:0] weight_below(logic [15:0] x, int s, int t);
        logic [41:0] acc;
        acc = '0;
        for (int i = s; i < t; i++)
            if (shadow_keys[i] < x)
                acc += {{10{shadow_wgts[i][31]}}, shadow_wgts[i]};
        return acc;
    endfunction

    function automatic t_answer predict_answer(t_req req, logic [15:0] key,
            logic [31:0] wgt, logic [10:0] s, logic [10:0] t,
            logic [15:0] lo, logic [15:0] hi);
        t_answer a;
        a = '0;
        a.status = ST_OK;
        case (req)
            REQ_APPEND: begin
                if (shadow_count >= STORE_DEPTH) begin
                    a.status = ST_FULL;
                end else begin
                    shadow_keys[shadow_count] = key;
                    shadow_wgts[shadow_count] = wgt;
                    shadow_count++;
                end
            end
            REQ_QUERY: begin
                if (s > t || t > shadow_count)
                    a.status = ST_RANGE;
                else
                    a.total = weight_below(hi, s, t) - weight_below(lo, s, t);
            end
            REQ_CLEAR: shadow_count = 0;
            default: ;
        endcase
        a.count = shadow_count[10:0];
        return a;
    endfunction

    // Send one transfer, then maybe leave a gap
    task automatic send_req(t_req req, logic [15:0] key, logic [31:0] wgt,
            logic [10:0] s, logic [10:0] t, logic [15:0] lo, logic [15:0] hi);
        t_answer expected;
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_item_key    <= key;
        i_item_weight <= wgt;
        i_range_start <= s;
        i_range_end   <= t;
        i_key_low     <= lo;
        i_key_high    <= hi;
        do @(posedge i_clk); while (o_stall);
        expected = predict_answer(req, key, wgt, s, t, lo, hi);
        answer_q = {answer_q, expected};
        @(negedge i_clk);
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic send_append(logic [15:0] key, logic [31:0] wgt);
        send_req(REQ_APPEND, key, wgt, 11'($urandom), 11'($urandom),
                 16'($urandom), 16'($urandom));
    endtask

    task automatic send_query(int s, int t, logic [15:0] lo, logic [15:0] hi);
        send_req(REQ_QUERY, 16'($urandom), $urandom, 11'(s), 11'(t), lo, hi);
    endtask

    task automatic test_directed();
        send_query(0, 0, 16'h0000, 16'hffff);
        send_query(0, 1, 16'h0000, 16'hffff);
        send_append(16'h0000, 32'h8000_0000);
        send_append(16'hffff, 32'h7fff_ffff);
        send_append(16'h8000, 32'hffff_ffff);
        send_append(16'h0001, 32'h0000_0001);
        send_query(0, 4, 16'h0000, 16'hffff);
        send_query(0, 4, 16'hffff, 16'h0000);
        send_query(1, 3, 16'h0001, 16'h8001);
        send_query(2, 2, 16'h0000, 16'hffff);
        send_query(3, 2, 16'h0000, 16'hffff);
        send_query(0, 5, 16'h0000, 16'hffff);
        send_query(2047, 2047, 16'h0000, 16'hffff);
        send_req(REQ_NONE, 16'hffff, 32'hffff_ffff, 11'h7ff, 11'h7ff, 16'hffff, 16'h0);
        send_req(REQ_CLEAR, 16'hffff, 32'hffff_ffff, 11'h7ff, 11'h7ff, 16'hffff, 16'h0);
        send_query(0, 0, 16'h0000, 16'h0001);
    endtask

    // Fill the store to capacity with large weights, then push past it
    task automatic test_full_store();
        for (int i = 0; i < STORE_DEPTH; i++)
            send_append(16'($urandom),
                        $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff);
        send_append(16'h1234, 32'h1);
        send_append(16'hffff, 32'hffff_ffff);
        send_query(0, 1024, 16'h0000, 16'hffff);
        send_query(1000, 1024, 16'hffff, 16'h0000);
        send_query(0, 1025, 16'h0000, 16'hffff);
        send_req(REQ_CLEAR, '0, '0, '0, '0, '0, '0);
    endtask

    // Short loads with random content, mostly valid queries on them
    task automatic test_random();
        int s;
        int t;
        for (int n = 0; n < 550; n++) begin
            case ($urandom_range(0, 19))
                0: send_req(REQ_CLEAR, 16'($urandom), $urandom, 11'($urandom),
                            11'($urandom), 16'($urandom), 16'($urandom));
                1: send_req(REQ_NONE, 16'($urandom), $urandom, 11'($urandom),
                            11'($urandom), 16'($urandom), 16'($urandom));
                2, 3, 4, 5, 6, 7, 8: send_append(16'($urandom), $urandom);
                9: send_query($urandom_range(0, 2047), $urandom_range(0, 2047),
                              16'($urandom), 16'($urandom));
                default: begin
                    if (shadow_count > 40)
                        send_req(REQ_CLEAR, '0, '0, '0, '0, '0, '0);
                    t = $urandom_range(0, shadow_count);
                    s = $urandom_range(0, t);
                    send_query(s, t, 16'($urandom), 16'($urandom));
                end
            endcase
        end
    endtask

    // Receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(0, 255) < 64) ? ($urandom_range(0, 2) == 0) : 1'b0;
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (answer_q.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                want = answer_q.pop_front();
                if (o_total !== want.total) begin
                    $error("total: expected %0d, got %0d", want.total, o_total);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_item_count !== want.count) begin
                    $error("item_count: expected %0d, got %0d", want.count, o_item_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog on transfer inactivity
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        shadow_count = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_full_store();
        test_random();
        i_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
